### hdl/bqab_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and codes of the bounded queue with acknowledgement backlog
package bqab_pkg;

  // ring geometry, depth is a power of two so ring indexes wrap by truncation
  localparam int DEPTH    = 256;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int MAX_ACK  = 64;
  localparam int ACK_W    = $clog2(MAX_ACK + 1);

  // fixed field widths
  localparam int CMD_W    = 3;
  localparam int HANDLE_W = 32;
  localparam int ENTRY_W  = HANDLE_W + 1;
  localparam int REQ_W    = 7;
  localparam int LIMIT_W  = 9;
  localparam int OUT_CNT_W = 9;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 56;

  localparam logic [LIMIT_W-1:0] QLIMIT_RESET = 9'd256;

  // configuration register indexes
  localparam logic CFG_QUEUE_LIMIT = 1'b0;
  localparam logic CFG_BACKLOG_EN  = 1'b1;

  // command codes, the three codes above rewind are no-ops
  localparam logic [CMD_W-1:0] CMD_PUSH_TAIL = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_HEAD = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP       = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ACK       = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REWIND    = 3'd4;

  typedef enum logic [1:0] {
    STAT_OK           = 2'd0,
    STAT_FULL         = 2'd1,
    STAT_EMPTY        = 2'd2,
    STAT_HEAD_REFUSED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_POP    = 2'd1,
    KIND_ACK    = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RESULT,
    S_POP_OUT,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_ACK_OUT
  } state_e;

  // one result item on its way to the output register
  typedef struct packed {
    status_e              status;
    kind_e                kind;
    logic [HANDLE_W-1:0]  handle;
    logic                 flow;
    logic [OUT_CNT_W-1:0] pending;
    logic [OUT_CNT_W-1:0] backlog;
    logic                 last;
  } result_t;

endpackage

### hdl/bounded_queue_with_ack_backlog.sv
`timescale 1ns / 1ps
// bounded queue with acknowledgement backlog: command sequencer around one entry memory
//
//  channel  | direction | carries
//  ---------+-----------+-----------------------------------------------------
//  cfg      | in        | queue_limit (index 0), backlog_enable (index 1)
//  s_axis   | in        | cmd in tuser; handle, flow bit, ack count in tdata
//  m_axis   | out       | kind in tuser; status, entry, counts in tdata; tlast
//
//  push tail, push head, rewind and unknown commands give one result; pop gives one and,
//  with the backlog off, then moves each backlog entry one slot along the ring. ack of n
//  entries gives n results, one a cycle from the single read port while m_axis is ready.
//  the 256 x 33 entry memory needs no clearing after reset; counters and pointers reset.
//  one command is in work at a time; a stalled m_axis holds the sequencer in a result state.
module bounded_queue_with_ack_backlog (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic                              cfg_idx_i,
  input  logic [bqab_pkg::LIMIT_W-1:0]      cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // msg_handle[31:0], flow_flag[32], ack_count[39:33]
  input  logic [bqab_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // cmd[2:0]
  input  logic [bqab_pkg::CMD_W-1:0]        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // status[1:0], out_handle[33:2], out_flow[34], pending_count[43:35],
  // backlog_count[52:44], zero fill above
  output logic [bqab_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // kind[1:0]
  output logic [1:0]                        m_axis_tuser,
  output logic                              m_axis_tlast
);
  import bqab_pkg::*;

  state_e             state_q, state_d;
  logic [IDX_W-1:0]   bs_q;
  logic [IDX_W-1:0]   ri_q;
  logic [CNT_W-1:0]   pend_q;
  logic [CNT_W-1:0]   bl_q;
  logic [LIMIT_W-1:0] qlimit_q;
  logic               blen_q;
  status_e            status_q;
  logic [IDX_W-1:0]   sh_ptr_q;
  logic [CNT_W-1:0]   sh_cnt_q;
  logic [ACK_W-1:0]   ack_cnt_q;

  logic [ENTRY_W-1:0] entry_mem [DEPTH];
  logic [ENTRY_W-1:0] rd_q;

  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic               mem_re;
  logic [IDX_W-1:0]   mem_raddr;

  logic               in_fire;
  logic               out_valid;
  logic               out_ready;
  logic               out_fire;
  result_t            result;

  logic [ENTRY_W-1:0] in_entry;
  logic [REQ_W-1:0]   in_req;
  logic               full_c;
  logic               tail_ok_c;
  logic               head_ok_c;
  logic [ACK_W-1:0]   ack_cnt_c;
  logic [31:0]        clamp_c;

  // input unpacking
  assign in_entry = {s_axis_tdata[HANDLE_W], s_axis_tdata[HANDLE_W-1:0]};
  assign in_req   = s_axis_tdata[HANDLE_W+1 +: REQ_W];
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = out_valid && out_ready;

  // command checks against the current counts
  always_comb begin
    full_c    = ({1'b0, pend_q} + {1'b0, bl_q}) >= (CNT_W+1)'(DEPTH);
    tail_ok_c = !full_c && ({{(LIMIT_W){1'b0}}, pend_q} < {{(CNT_W){1'b0}}, qlimit_q});
    head_ok_c = !full_c && (bl_q == '0);
    clamp_c   = 32'(in_req);
    if (clamp_c > 32'(bl_q)) begin
      clamp_c = 32'(bl_q);
    end
    if (clamp_c > 32'(MAX_ACK)) begin
      clamp_c = 32'(MAX_ACK);
    end
    ack_cnt_c = ACK_W'(clamp_c);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (s_axis_tuser == CMD_POP && pend_q != '0) begin
            state_d = S_POP_OUT;
          end else if (s_axis_tuser == CMD_ACK && ack_cnt_c != '0) begin
            state_d = S_ACK_OUT;
          end else begin
            state_d = S_RESULT;
          end
        end
      end
      S_RESULT: begin
        if (out_ready) begin
          state_d = S_IDLE;
        end
      end
      S_POP_OUT: begin
        if (out_ready) begin
          state_d = (sh_cnt_q != '0) ? S_SHIFT_RD : S_IDLE;
        end
      end
      S_SHIFT_RD: begin
        state_d = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        state_d = (sh_cnt_q == CNT_W'(1)) ? S_IDLE : S_SHIFT_RD;
      end
      S_ACK_OUT: begin
        if (out_ready && ack_cnt_q == ACK_W'(1)) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // outputs: handshake, result item and memory ports
  always_comb begin
    s_axis_tready  = 1'b0;
    out_valid      = 1'b0;
    result.status  = status_q;
    result.kind    = KIND_STATUS;
    result.handle  = '0;
    result.flow    = 1'b0;
    result.pending = OUT_CNT_W'(pend_q);
    result.backlog = OUT_CNT_W'(bl_q);
    result.last    = 1'b1;
    mem_we         = 1'b0;
    mem_waddr      = ri_q;
    mem_wdata      = in_entry;
    mem_re         = 1'b0;
    mem_raddr      = ri_q;
    case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (in_fire) begin
          case (s_axis_tuser)
            CMD_PUSH_TAIL: begin
              mem_we    = tail_ok_c;
              mem_waddr = ri_q + pend_q[IDX_W-1:0];
            end
            CMD_PUSH_HEAD: begin
              mem_we    = head_ok_c;
              mem_waddr = ri_q - IDX_W'(1);
            end
            CMD_POP: begin
              mem_re    = (pend_q != '0);
              mem_raddr = ri_q;
            end
            CMD_ACK: begin
              mem_re    = (ack_cnt_c != '0);
              mem_raddr = bs_q;
            end
            default: begin
            end
          endcase
        end
      end
      S_RESULT: begin
        out_valid = 1'b1;
      end
      S_POP_OUT: begin
        out_valid     = 1'b1;
        result.status = STAT_OK;
        result.kind   = KIND_POP;
        result.handle = rd_q[HANDLE_W-1:0];
        result.flow   = rd_q[HANDLE_W];
      end
      S_SHIFT_RD: begin
        mem_re    = 1'b1;
        mem_raddr = sh_ptr_q - IDX_W'(1);
      end
      S_SHIFT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = sh_ptr_q;
        mem_wdata = rd_q;
      end
      S_ACK_OUT: begin
        out_valid     = 1'b1;
        result.status = STAT_OK;
        result.kind   = KIND_ACK;
        result.handle = rd_q[HANDLE_W-1:0];
        result.flow   = rd_q[HANDLE_W];
        result.last   = (ack_cnt_q == ACK_W'(1));
        // fetch the next backlog entry as this one leaves
        mem_re        = out_ready && (ack_cnt_q > ACK_W'(1));
        mem_raddr     = bs_q;
      end
      default: begin
      end
    endcase
  end

  // ring pointers, counts, configuration and sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      bs_q      <= '0;
      ri_q      <= '0;
      pend_q    <= '0;
      bl_q      <= '0;
      qlimit_q  <= QLIMIT_RESET;
      blen_q    <= 1'b1;
      status_q  <= STAT_OK;
      sh_ptr_q  <= '0;
      sh_cnt_q  <= '0;
      ack_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_QUEUE_LIMIT: qlimit_q <= cfg_data_i;
          CFG_BACKLOG_EN:  blen_q   <= cfg_data_i[0];
          default: begin
          end
        endcase
      end
      if (in_fire) begin
        case (s_axis_tuser)
          CMD_PUSH_TAIL: begin
            if (tail_ok_c) begin
              pend_q   <= pend_q + CNT_W'(1);
              status_q <= STAT_OK;
            end else begin
              status_q <= STAT_FULL;
            end
          end
          CMD_PUSH_HEAD: begin
            if (head_ok_c) begin
              ri_q     <= ri_q - IDX_W'(1);
              bs_q     <= ri_q - IDX_W'(1);
              pend_q   <= pend_q + CNT_W'(1);
              status_q <= STAT_OK;
            end else begin
              status_q <= STAT_HEAD_REFUSED;
            end
          end
          CMD_POP: begin
            if (pend_q == '0) begin
              status_q <= STAT_EMPTY;
              sh_cnt_q <= '0;
            end else begin
              status_q <= STAT_OK;
              pend_q   <= pend_q - CNT_W'(1);
              ri_q     <= ri_q + IDX_W'(1);
              if (blen_q) begin
                bl_q     <= bl_q + CNT_W'(1);
                sh_cnt_q <= '0;
              end else begin
                // backlog moves one slot on so it stays ahead of pending
                bs_q     <= bs_q + IDX_W'(1);
                sh_ptr_q <= ri_q;
                sh_cnt_q <= bl_q;
              end
            end
          end
          CMD_ACK: begin
            if (ack_cnt_c == '0) begin
              status_q <= (bl_q == '0) ? STAT_EMPTY : STAT_OK;
            end else begin
              status_q  <= STAT_OK;
              bl_q      <= bl_q - CNT_W'(ack_cnt_c);
              bs_q      <= bs_q + IDX_W'(1);
              ack_cnt_q <= ack_cnt_c;
            end
          end
          CMD_REWIND: begin
            status_q <= STAT_OK;
            ri_q     <= bs_q;
            pend_q   <= pend_q + bl_q;
            bl_q     <= '0;
          end
          default: begin
            status_q <= STAT_OK;
          end
        endcase
      end
      // ack walk
      if (state_q == S_ACK_OUT && out_fire) begin
        ack_cnt_q <= ack_cnt_q - ACK_W'(1);
        if (ack_cnt_q > ACK_W'(1)) begin
          bs_q <= bs_q + IDX_W'(1);
        end
      end
      // backlog shift, top entry first
      if (state_q == S_SHIFT_WR) begin
        sh_ptr_q <= sh_ptr_q - IDX_W'(1);
        sh_cnt_q <= sh_cnt_q - CNT_W'(1);
      end
    end
  end

  // entry memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      entry_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_q <= entry_mem[mem_raddr];
    end
  end

  // output register
  bqab_out_reg u_out_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (out_valid),
    .result_i      (result),
    .ready_o       (out_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

### hdl/bqab_out_reg.sv
`timescale 1ns / 1ps
// output register that holds one result and packs it onto the master stream
module bqab_out_reg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  input  bqab_pkg::result_t                  result_i,
  output logic                               ready_o,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // status[1:0], out_handle[33:2], out_flow[34], pending_count[43:35],
  // backlog_count[52:44], zero fill above
  output logic [bqab_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // kind[1:0]
  output logic [1:0]                         m_axis_tuser,
  output logic                               m_axis_tlast
);
  import bqab_pkg::*;

  logic    valid_q;
  result_t res_q;

  // free when empty or when the held result leaves in this cycle
  assign ready_o = !valid_q || m_axis_tready;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      res_q <= result_i;
    end
  end

  // packing
  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {3'b000, res_q.backlog, res_q.pending, res_q.flow,
                          res_q.handle, res_q.status};
  assign m_axis_tuser  = res_q.kind;
  assign m_axis_tlast  = res_q.last;

endmodule

### hdl/bqab_checker.sv
`timescale 1ns / 1ps
// port-level checker for the bounded queue with acknowledgement backlog, with its bind
module bqab_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              cfg_we_i,
  input logic                              cfg_idx_i,
  input logic [bqab_pkg::LIMIT_W-1:0]      cfg_data_i,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic [bqab_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  input logic [bqab_pkg::CMD_W-1:0]        s_axis_tuser,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [bqab_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input logic [1:0]                        m_axis_tuser,
  input logic                              m_axis_tlast
);
  import bqab_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // one command at a time: ready drops after every input transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a command is in work");

  // status-only results carry no entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_STATUS |-> m_axis_tdata[34:2] == '0)
    else $error("status-only result carries an entry");

  // a pop result is ok and closes its command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_POP |-> m_axis_tlast && m_axis_tdata[1:0] == STAT_OK)
    else $error("pop result malformed");

  // the two parts never exceed the ring
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ({1'b0, m_axis_tdata[43:35]} + {1'b0, m_axis_tdata[52:44]}) <= 10'(DEPTH))
    else $error("pending and backlog exceed ring depth");

endmodule

bind bounded_queue_with_ack_backlog bqab_checker u_bqab_checker (.*);

### tb/tb_bounded_queue_with_ack_backlog.sv
`timescale 1ns / 1ps
// testbench of the bounded queue with acknowledgement backlog, self-checking against a queue predictor
module tb_bounded_queue_with_ack_backlog;
  import bqab_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 400;
  localparam int MAX_PRINTED    = 40;

  // spare command codes, treated as no-ops by the block
  localparam logic [CMD_W-1:0] CMD_SPARE5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic                   cfg_idx_i;
  logic [LIMIT_W-1:0]     cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  // msg_handle[31:0], flow_flag[32], ack_count[39:33]
  logic [IN_DATA_W-1:0]   s_axis_tdata;
  // cmd[2:0]
  logic [CMD_W-1:0]       s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // status[1:0], out_handle[33:2], out_flow[34], pending_count[43:35], backlog_count[52:44]
  logic [OUT_DATA_W-1:0]  m_axis_tdata;
  // kind[1:0]
  logic [1:0]             m_axis_tuser;
  logic                   m_axis_tlast;

  bounded_queue_with_ack_backlog dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // clock
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // predictor state: ring, backlog head, read pointer, counts, configuration
  logic [ENTRY_W-1:0] ring_mem [DEPTH];
  int                 bl_head;
  int                 rd_ptr;
  int                 n_pend;
  int                 n_blog;
  int                 lim;
  bit                 keep_backlog;

  result_t step_results[$];
  result_t expected_results[$];

  int  errors;
  int  cmds_sent;
  int  results_seen;
  int  cfg_writes;
  int  peak_fill;
  int  ack_clamps;
  int  full_refusals;
  bit  idle_on;
  bit  stall_on;
  bit  hold_req;

  // directed stimulus, expected result typed in where it is obvious
  typedef struct {
    logic [CMD_W-1:0]    cmd;
    logic [HANDLE_W-1:0] handle;
    logic                flow;
    logic [REQ_W-1:0]    req;
    bit                  typed;
    status_e             st;
    int                  pend;
    int                  blog;
  } dir_row_t;

  localparam int NDIR = 23;
  dir_row_t dir_rows [NDIR] = '{
    '{CMD_POP,       32'h0000_0000, 1'b0, 7'd0,   1'b1, STAT_EMPTY,        0, 0},
    '{CMD_ACK,       32'h0000_0000, 1'b0, 7'd0,   1'b1, STAT_EMPTY,        0, 0},
    '{CMD_ACK,       32'h0000_0000, 1'b0, 7'd127, 1'b1, STAT_EMPTY,        0, 0},
    '{CMD_REWIND,    32'h0000_0000, 1'b0, 7'd0,   1'b1, STAT_OK,           0, 0},
    '{CMD_SPARE5,    32'h0000_0000, 1'b0, 7'd0,   1'b1, STAT_OK,           0, 0},
    '{CMD_SPARE6,    32'hdead_beef, 1'b1, 7'd5,   1'b1, STAT_OK,           0, 0},
    '{CMD_SPARE7,    32'hffff_ffff, 1'b1, 7'd127, 1'b1, STAT_OK,           0, 0},
    '{CMD_PUSH_TAIL, 32'hffff_ffff, 1'b1, 7'd0,   1'b1, STAT_OK,           1, 0},
    '{CMD_PUSH_TAIL, 32'h0000_0000, 1'b0, 7'd0,   1'b1, STAT_OK,           2, 0},
    '{CMD_PUSH_HEAD, 32'h5a5a_5a5a, 1'b1, 7'd127, 1'b1, STAT_OK,           3, 0},
    '{CMD_POP,       32'h0000_0000, 1'b0, 7'd0,   1'b0, STAT_OK,           0, 0},
    '{CMD_POP,       32'h0000_0000, 1'b0, 7'd0,   1'b0, STAT_OK,           0, 0},
    '{CMD_PUSH_HEAD, 32'ha5a5_a5a5, 1'b1, 7'd0,   1'b1, STAT_HEAD_REFUSED, 1, 2},
    '{CMD_PUSH_TAIL, 32'h1234_5678, 1'b1, 7'd0,   1'b1, STAT_OK,           2, 2},
    '{CMD_ACK,       32'h0000_0000, 1'b0, 7'd0,   1'b1, STAT_OK,           2, 2},
    '{CMD_ACK,       32'h0000_0000, 1'b0, 7'd1,   1'b0, STAT_OK,           0, 0},
    '{CMD_REWIND,    32'h0000_0000, 1'b0, 7'd0,   1'b1, STAT_OK,           3, 0},
    '{CMD_POP,       32'h0000_0000, 1'b0, 7'd0,   1'b0, STAT_OK,           0, 0},
    '{CMD_POP,       32'h0000_0000, 1'b0, 7'd0,   1'b0, STAT_OK,           0, 0},
    '{CMD_POP,       32'h0000_0000, 1'b0, 7'd0,   1'b0, STAT_OK,           0, 0},
    '{CMD_ACK,       32'h0000_0000, 1'b0, 7'd127, 1'b0, STAT_OK,           0, 0},
    '{CMD_POP,       32'h0000_0000, 1'b0, 7'd0,   1'b1, STAT_EMPTY,        0, 0},
    '{CMD_ACK,       32'h0000_0000, 1'b0, 7'd64,  1'b1, STAT_EMPTY,        0, 0}
  };

  // mismatch report, one line each, printing capped
  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MAX_PRINTED) $display("mismatch at result %0d: %s", results_seen, msg);
  endtask

  // queue predictor: applies one command and lists the results it gives
  task automatic queue_step(input logic [CMD_W-1:0] cmd, input logic [HANDLE_W-1:0] handle,
                            input logic flow, input logic [REQ_W-1:0] req);
    bit                 full;
    int                 cnt;
    logic [ENTRY_W-1:0] e;
    result_t            r;
    step_results.delete();
    full = (n_pend + n_blog) >= DEPTH;
    r = '0;
    r.status = STAT_OK;
    r.kind = KIND_STATUS;
    case (cmd)
      CMD_PUSH_TAIL: begin
        if (full || n_pend >= lim) begin
          r.status = STAT_FULL;
          full_refusals++;
        end else begin
          ring_mem[(rd_ptr + n_pend) % DEPTH] = {flow, handle};
          n_pend++;
        end
        step_results.push_back(r);
      end
      CMD_PUSH_HEAD: begin
        if (full || n_blog != 0) begin
          r.status = STAT_HEAD_REFUSED;
        end else begin
          rd_ptr = (rd_ptr + DEPTH - 1) % DEPTH;
          ring_mem[rd_ptr] = {flow, handle};
          bl_head = rd_ptr;
          n_pend++;
        end
        step_results.push_back(r);
      end
      CMD_POP: begin
        if (n_pend == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          e = ring_mem[rd_ptr];
          n_pend--;
          if (keep_backlog) begin
            n_blog++;
          end else begin
            // backlog slides one slot along to stay in front of pending
            for (int i = n_blog; i > 0; i--)
              ring_mem[(bl_head + i) % DEPTH] = ring_mem[(bl_head + i - 1) % DEPTH];
            bl_head = (bl_head + 1) % DEPTH;
          end
          rd_ptr = (rd_ptr + 1) % DEPTH;
          r.kind = KIND_POP;
          r.handle = e[HANDLE_W-1:0];
          r.flow = e[HANDLE_W];
        end
        step_results.push_back(r);
      end
      CMD_ACK: begin
        cnt = int'(req);
        if (cnt > n_blog) cnt = n_blog;
        if (cnt > MAX_ACK) begin
          cnt = MAX_ACK;
          ack_clamps++;
        end
        if (cnt == 0) begin
          r.status = (n_blog == 0) ? STAT_EMPTY : STAT_OK;
          step_results.push_back(r);
        end else begin
          r.kind = KIND_ACK;
          for (int k = 0; k < cnt; k++) begin
            e = ring_mem[bl_head];
            r.handle = e[HANDLE_W-1:0];
            r.flow = e[HANDLE_W];
            step_results.push_back(r);
            bl_head = (bl_head + 1) % DEPTH;
          end
          n_blog -= cnt;
        end
      end
      CMD_REWIND: begin
        rd_ptr = bl_head;
        n_pend += n_blog;
        n_blog = 0;
        step_results.push_back(r);
      end
      default: step_results.push_back(r);
    endcase
    // counts are those after the whole command
    foreach (step_results[k]) begin
      step_results[k].pending = OUT_CNT_W'(n_pend);
      step_results[k].backlog = OUT_CNT_W'(n_blog);
    end
    step_results[step_results.size() - 1].last = 1'b1;
    if (n_pend + n_blog > peak_fill) peak_fill = n_pend + n_blog;
  endtask

  // one command transfer on the input side, with an optional idle burst first
  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [HANDLE_W-1:0] handle,
                          input logic flow, input logic [REQ_W-1:0] req);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {req, flow, handle};
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    cmds_sent++;
  endtask

  // send and queue the predicted results
  task automatic issue(input logic [CMD_W-1:0] cmd, input logic [HANDLE_W-1:0] handle,
                       input logic flow, input logic [REQ_W-1:0] req);
    send_cmd(cmd, handle, flow, req);
    queue_step(cmd, handle, flow, req);
    foreach (step_results[k]) expected_results.push_back(step_results[k]);
  endtask

  // random command, weighted towards well-formed queue traffic
  task automatic issue_random();
    int               pick;
    int               sel;
    logic [CMD_W-1:0] cmd;
    logic [REQ_W-1:0] req;
    pick = $urandom_range(0, 99);
    if (pick < 35)      cmd = CMD_PUSH_TAIL;
    else if (pick < 45) cmd = CMD_PUSH_HEAD;
    else if (pick < 70) cmd = CMD_POP;
    else if (pick < 87) cmd = CMD_ACK;
    else if (pick < 93) cmd = CMD_REWIND;
    else if (pick < 95) cmd = CMD_SPARE5;
    else if (pick < 97) cmd = CMD_SPARE6;
    else                cmd = CMD_SPARE7;
    sel = $urandom_range(0, 19);
    if (sel < 12)      req = REQ_W'($urandom_range(1, 6));
    else if (sel < 14) req = '0;
    else if (sel < 17) req = REQ_W'($urandom_range(7, MAX_ACK));
    else               req = REQ_W'($urandom_range(MAX_ACK + 1, 127));
    issue(cmd, $urandom, 1'($urandom_range(0, 1)), req);
  endtask

  // wait until every expected result has come back and the block is idle again
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // write both registers while the block is idle
  task automatic set_config(input int limit, input bit keep);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_QUEUE_LIMIT;
    cfg_data_i <= LIMIT_W'(limit);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_BACKLOG_EN;
    cfg_data_i <= LIMIT_W'(keep);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    lim = limit;
    keep_backlog = keep;
    cfg_writes += 2;
  endtask

  task automatic run_mix(input int n_cmds, input int limit, input bit keep);
    set_config(limit, keep);
    repeat (n_cmds) issue_random();
  endtask

  // result side: compare each transfer with the oldest expectation, random stalls
  task automatic check_result();
    result_t want;
    results_seen++;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result, tdata %h", m_axis_tdata));
      return;
    end
    want = expected_results.pop_front();
    if (m_axis_tdata[1:0] !== want.status)
      report_mismatch($sformatf("status %0d, want %0d", m_axis_tdata[1:0], want.status));
    if (m_axis_tuser !== want.kind)
      report_mismatch($sformatf("kind %0d, want %0d", m_axis_tuser, want.kind));
    if (m_axis_tdata[33:2] !== want.handle)
      report_mismatch($sformatf("handle %h, want %h", m_axis_tdata[33:2], want.handle));
    if (m_axis_tdata[34] !== want.flow)
      report_mismatch($sformatf("flow %b, want %b", m_axis_tdata[34], want.flow));
    if (m_axis_tdata[43:35] !== want.pending)
      report_mismatch($sformatf("pending %0d, want %0d", m_axis_tdata[43:35], want.pending));
    if (m_axis_tdata[52:44] !== want.backlog)
      report_mismatch($sformatf("backlog %0d, want %0d", m_axis_tdata[52:44], want.backlog));
    if (m_axis_tlast !== want.last)
      report_mismatch($sformatf("tlast %b, want %b", m_axis_tlast, want.last));
  endtask

  initial begin : result_sink
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) check_result();
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 15) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any transfer
  int quiet_cycles;
  initial quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i ||
        !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus
  initial begin : stimulus
    result_t typed_want;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_QUEUE_LIMIT;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_PUSH_TAIL;
    errors = 0;
    cmds_sent = 0;
    results_seen = 0;
    cfg_writes = 0;
    peak_fill = 0;
    ack_clamps = 0;
    full_refusals = 0;
    idle_on = 1'b1;
    stall_on = 1'b1;
    hold_req = 1'b0;
    bl_head = 0;
    rd_ptr = 0;
    n_pend = 0;
    n_blog = 0;
    lim = int'(QLIMIT_RESET);
    keep_backlog = 1'b1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table under the reset configuration
    foreach (dir_rows[i]) begin
      if (dir_rows[i].typed) begin
        send_cmd(dir_rows[i].cmd, dir_rows[i].handle, dir_rows[i].flow, dir_rows[i].req);
        queue_step(dir_rows[i].cmd, dir_rows[i].handle, dir_rows[i].flow, dir_rows[i].req);
        typed_want = '0;
        typed_want.status  = dir_rows[i].st;
        typed_want.kind    = KIND_STATUS;
        typed_want.pending = OUT_CNT_W'(dir_rows[i].pend);
        typed_want.backlog = OUT_CNT_W'(dir_rows[i].blog);
        typed_want.last    = 1'b1;
        expected_results.push_back(typed_want);
      end else begin
        issue(dir_rows[i].cmd, dir_rows[i].handle, dir_rows[i].flow, dir_rows[i].req);
      end
    end

    // tight limit, then a limit of zero and then the full depth, both with the backlog off
    run_mix(25, 1, 1'b1);
    run_mix(20, 0, 1'b0);
    run_mix(30, DEPTH, 1'b0);

    // fill the ring to the brim while the result side holds off
    set_config(DEPTH, 1'b1);
    issue(CMD_REWIND, '0, 1'b0, '0);
    hold_req = 1'b1;
    while (n_pend + n_blog < DEPTH)
      issue(CMD_PUSH_TAIL, $urandom, 1'($urandom_range(0, 1)), '0);
    issue(CMD_PUSH_TAIL, $urandom, 1'b1, '0);
    issue(CMD_PUSH_TAIL, $urandom, 1'b0, '0);
    issue(CMD_PUSH_HEAD, $urandom, 1'b1, '0);
    repeat (70) issue(CMD_POP, $urandom, 1'b0, '0);
    issue(CMD_ACK, '0, 1'b0, 7'd127);
    issue(CMD_PUSH_HEAD, $urandom, 1'b1, '0);
    repeat (20) issue(CMD_POP, $urandom, 1'b0, '0);

    // backlog off with a long backlog, so pops slide many entries, then a limit of 100 with it on
    run_mix(10, DEPTH, 1'b0);
    run_mix(20, 100, 1'b1);

    // last stretch without idling on either side
    drain();
    idle_on = 1'b0;
    stall_on = 1'b0;
    run_mix(30, 511, 1'b1);

    drain();
    repeat (20) @(posedge clk_i);
    $display("run covered %0d commands, %0d results, %0d register writes", cmds_sent,
             results_seen, cfg_writes);
    $display("ring peak %0d entries, %0d clamped acks, %0d push tail refusals", peak_fill,
             ack_clamps, full_refusals);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
